FILE: rtl/ckit_pkg.sv
`default_nettype none

package ckit_pkg;

    // Table geometry.
    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    // Command codes carried on the input channel.
    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    // Status codes returned on the output channel.
    typedef enum logic [1:0] {
        ST_PRESENT = 2'd0,
        ST_ADDED   = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // Control broadcast from the top level to every cell of the row.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] pos;
        logic             append;
        logic             remove;
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: rtl/ckit_cell.sv
`default_nettype none

module ckit_cell
    import ckit_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire t_cell_ctrl           i_ctrl,
    input  wire logic [IDX_W-1:0]     i_index,
    input  wire logic [KEY_WIDTH-1:0] i_key,
    input  wire logic [KEY_WIDTH-1:0] i_next_key,
    output      logic [KEY_WIDTH-1:0] o_key,
    output      logic                 o_match
);

    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] n_key;
    logic                 w_in_use;

    // The cell holds a live key only below the current fill level.
    assign w_in_use = {1'b0, i_index} < i_ctrl.count;
    assign o_match  = w_in_use && (r_key == i_key);
    assign o_key    = r_key;

    // An append lands in the first free cell; a remove pulls the neighbor's
    // key into every cell at or above the removed position.
    always_comb begin
        n_key = r_key;
        if (i_ctrl.append && ({1'b0, i_index} == i_ctrl.count)) begin
            n_key = i_key;
        end else if (i_ctrl.remove && (i_index >= i_ctrl.pos)) begin
            n_key = i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

`default_nettype wire

FILE: rtl/compacting_key_index_table.sv
`default_nettype none

// Compacting key index table: a dense, ordered list of up to CAPACITY distinct
// keys, where a key's position is its index. Each transaction carries a
// command (lookup, add or remove) and a key, and yields exactly one result
// with a status, the key's index and the number of keys held afterwards. The
// keys live in a row of cells; every cell compares its key with the incoming
// one in parallel and, on a remove, each cell at or above the removed position
// takes its upper neighbor's key. The block takes one transaction per cycle;
// the result appears in an output register in the cycle after acceptance, and
// a new transaction is accepted whenever that register is empty or its result
// is taken in the same cycle. No clearing pass is needed after reset.
module compacting_key_index_table
    import ckit_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output      logic             o_in_ready,
    input  wire logic [1:0]       i_cmd,
    input  wire logic [31:0]      i_key_value,
    output      logic             o_out_valid,
    input  wire logic             i_out_ready,
    output      logic [1:0]       o_status,
    output      logic [IDX_W-1:0] o_slot_index,
    output      logic [CNT_W-1:0] o_occupancy
);

    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    t_status              r_status;
    t_status              n_status;
    logic [IDX_W-1:0]     r_slot;
    logic [IDX_W-1:0]     n_slot;

    logic                 w_accept;
    logic [KEY_WIDTH-1:0] w_key;
    logic [CAPACITY-1:0]  w_match;
    logic                 w_hit;
    logic [IDX_W-1:0]     w_pos;
    logic                 w_full;
    t_cell_ctrl           w_ctrl;
    logic [KEY_WIDTH-1:0] w_cell_key [CAPACITY];

    assign w_accept = i_in_valid && o_in_ready;
    assign w_key    = i_key_value[KEY_WIDTH-1:0];
    assign w_full   = r_count >= CNT_W'(CAPACITY);

    // Keys are distinct, so at most one cell matches; OR its index together.
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_match[i]) begin
                w_pos = w_pos | IDX_W'(i);
            end
        end
    end
    assign w_hit = |w_match;

    // Command decode, result and new fill level.
    always_comb begin
        n_status = ST_ABSENT;
        n_slot   = '0;
        n_count  = r_count;
        case (t_cmd'(i_cmd))
            CMD_ADD: begin
                if (w_hit) begin
                    n_status = ST_PRESENT;
                    n_slot   = w_pos;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_ADDED;
                    n_slot   = r_count[IDX_W-1:0];
                    n_count  = r_count + CNT_W'(1);
                end
            end
            CMD_REMOVE: begin
                if (w_hit) begin
                    n_status = ST_PRESENT;
                    n_slot   = w_pos;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            default: begin
                if (w_hit) begin
                    n_status = ST_PRESENT;
                    n_slot   = w_pos;
                end
            end
        endcase
    end

    // Control broadcast to the cell row.
    always_comb begin
        w_ctrl.count  = r_count;
        w_ctrl.pos    = w_pos;
        w_ctrl.append = w_accept && (t_cmd'(i_cmd) == CMD_ADD) && !w_hit && !w_full;
        w_ctrl.remove = w_accept && (t_cmd'(i_cmd) == CMD_REMOVE) && w_hit;
    end

    // The row of key cells; the top cell feeds back its own key on a shift.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_WIDTH-1:0] w_next;
        if (g == CAPACITY - 1) begin : g_top
            assign w_next = w_cell_key[g];
        end else begin : g_mid
            assign w_next = w_cell_key[g + 1];
        end
        ckit_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_index    (IDX_W'(g)),
            .i_key      (w_key),
            .i_next_key (w_next),
            .o_key      (w_cell_key[g]),
            .o_match    (w_match[g])
        );
    end

    // Output register handshake.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign n_out_valid = w_accept || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_slot   <= n_slot;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_slot_index = r_slot;
    assign o_occupancy  = r_count;

endmodule

`default_nettype wire

FILE: rtl/ckit_checker.sv
`default_nettype none

module ckit_checker
    import ckit_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             o_out_valid,
    input  wire logic             i_out_ready,
    input  wire logic [1:0]       o_status,
    input  wire logic [IDX_W-1:0] o_slot_index,
    input  wire logic [CNT_W-1:0] o_occupancy
);

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result holds its status.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("stalled result changed");

    // A newly added key lands at the end of the list.
    a_added_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_ADDED) |->
            o_slot_index == IDX_W'(o_occupancy - CNT_W'(1)))
        else $error("added key not at end of list");

    // A refused add only happens on a full table, with index zero.
    a_full_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |->
            (o_occupancy == CNT_W'(CAPACITY)) && (o_slot_index == '0))
        else $error("full status on a table with room");

    // The fill level never exceeds the capacity.
    a_occupancy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_occupancy <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

endmodule

bind compacting_key_index_table ckit_checker u_ckit_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_status     (o_status),
    .o_slot_index (o_slot_index),
    .o_occupancy  (o_occupancy)
);

`default_nettype wire
